>>> sv/ism_pkg.sv
// ---------------------------------------------------------------------------
// ism_pkg - IUPAC symbol match shared definitions
// Base codes, character constants, per-character info type and the
// character classification functions used by the match datapath.
// ---------------------------------------------------------------------------
package ism_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned BaseWidth = 4;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [BaseWidth-1:0] base_type;

   localparam base_type BaseA = 4'h1;
   localparam base_type BaseC = 4'h2;
   localparam base_type BaseG = 4'h4;
   localparam base_type BaseT = 4'h8;
   localparam base_type BaseNone = 4'h0;

   localparam char_type CharA = 8'h41;
   localparam char_type CharB = 8'h42;
   localparam char_type CharC = 8'h43;
   localparam char_type CharD = 8'h44;
   localparam char_type CharE = 8'h45;
   localparam char_type CharG = 8'h47;
   localparam char_type CharH = 8'h48;
   localparam char_type CharK = 8'h4B;
   localparam char_type CharM = 8'h4D;
   localparam char_type CharN = 8'h4E;
   localparam char_type CharQ = 8'h51;
   localparam char_type CharR = 8'h52;
   localparam char_type CharS = 8'h53;
   localparam char_type CharT = 8'h54;
   localparam char_type CharU = 8'h55;
   localparam char_type CharV = 8'h56;
   localparam char_type CharW = 8'h57;
   localparam char_type CharX = 8'h58;
   localparam char_type CharY = 8'h59;
   localparam char_type CharZ = 8'h5A;
   localparam char_type CharLowA = 8'h61;
   localparam char_type CharLowZ = 8'h7A;
   localparam char_type CharDash = 8'h2D;
   localparam char_type CharDot = 8'h2E;
   localparam char_type CaseOffset = 8'h20;

   localparam logic AlphabetNucleotide = 1'b0;
   localparam logic AlphabetAmino = 1'b1;

   typedef struct packed {
      char_type raw;
      char_type upper;
      logic     letter;
      logic     gap;
      base_type single;
      base_type set;
   } char_info_type;

   function automatic char_type to_upper(input char_type c);
      char_type u;
      u = c;
      if (c inside {[CharLowA:CharLowZ]}) begin
         u = c - CaseOffset;
      end
      return u;
   endfunction

   function automatic base_type single_base(input char_type u);
      base_type b;
      case (u)
         CharA: begin
            b = BaseA;
         end
         CharC: begin
            b = BaseC;
         end
         CharG: begin
            b = BaseG;
         end
         CharT, CharU: begin
            b = BaseT;
         end
         default: begin
            b = BaseNone;
         end
      endcase
      return b;
   endfunction

   function automatic base_type base_set(input char_type u);
      base_type b;
      case (u)
         CharM: begin
            b = BaseA | BaseC;
         end
         CharR: begin
            b = BaseA | BaseG;
         end
         CharW: begin
            b = BaseA | BaseT;
         end
         CharS: begin
            b = BaseC | BaseG;
         end
         CharY: begin
            b = BaseC | BaseT;
         end
         CharK: begin
            b = BaseG | BaseT;
         end
         CharV: begin
            b = BaseA | BaseC | BaseG;
         end
         CharH: begin
            b = BaseA | BaseC | BaseT;
         end
         CharD: begin
            b = BaseA | BaseG | BaseT;
         end
         CharB: begin
            b = BaseC | BaseG | BaseT;
         end
         CharX, CharN: begin
            b = BaseA | BaseC | BaseG | BaseT;
         end
         default: begin
            b = single_base(u);
         end
      endcase
      return b;
   endfunction

endpackage

>>> sv/ism_classify.sv
// ---------------------------------------------------------------------------
// ism_classify - character classification
// Folds case and derives letter/gap flags and nucleotide base sets for one
// sequence character.
// ---------------------------------------------------------------------------
module ism_classify (
   input  ism_pkg::char_type      char_in,
   output ism_pkg::char_info_type info
);

   ism_pkg::char_type upper;

   assign upper = ism_pkg::to_upper(char_in);

   always_comb begin
      info.raw    = char_in;
      info.upper  = upper;
      info.letter = (upper >= ism_pkg::CharA) && (upper <= ism_pkg::CharZ);
      info.gap    = (char_in == ism_pkg::CharDash) || (char_in == ism_pkg::CharDot);
      info.single = ism_pkg::single_base(upper);
      info.set    = ism_pkg::base_set(upper);
   end

endmodule

>>> sv/ism_compare.sv
// ---------------------------------------------------------------------------
// ism_compare - pair match decision
// Combines two classified characters into the match flag for the selected
// alphabet.
// ---------------------------------------------------------------------------
module ism_compare (
   input  ism_pkg::char_info_type first_info,
   input  ism_pkg::char_info_type second_info,
   input  logic                   alphabet_mode,
   output logic                   is_match
);

   logic same;
   logic any_x;
   logic pair_fs;
   logic pair_sf;
   logic nuc_hit;

   // amino B/Z extension is uppercase only, so compare raw bytes
   function automatic logic amino_pair(input ism_pkg::char_type p,
                                       input ism_pkg::char_type q);
      return ((p == ism_pkg::CharB) && ((q == ism_pkg::CharN) || (q == ism_pkg::CharD))) ||
             ((p == ism_pkg::CharZ) && ((q == ism_pkg::CharQ) || (q == ism_pkg::CharE)));
   endfunction

   assign same    = first_info.upper == second_info.upper;
   assign any_x   = (first_info.upper == ism_pkg::CharX) || (second_info.upper == ism_pkg::CharX);
   assign pair_fs = amino_pair(first_info.raw, second_info.raw);
   assign pair_sf = amino_pair(second_info.raw, first_info.raw);
   assign nuc_hit = |(first_info.single & second_info.set) ||
                    |(second_info.single & first_info.set);

   always_comb begin
      if (!first_info.letter || !second_info.letter) begin
         is_match = first_info.gap && second_info.gap;
      end else if (same) begin
         is_match = 1'b1;
      end else if (alphabet_mode == ism_pkg::AlphabetAmino) begin
         is_match = any_x || pair_fs || pair_sf;
      end else begin
         is_match = nuc_hit;
      end
   end

endmodule

>>> sv/iupac_symbol_match.sv
// ---------------------------------------------------------------------------
// iupac_symbol_match - sequence character pair match
// A transaction is taken on every cycle in which start is high; busy never
// rises. The result appears on rsp_is_match with rsp_strobe high for one
// cycle, after one register stage on the characters, then the classify and
// compare logic into the result register (rsp_match_ff, rsp_valid_ff).
// One comparison per clock is sustained. The receiver cannot stall, so
// every result must be taken in its strobe cycle. alphabet_mode (csr_wdata)
// selects nucleotide (0) or amino acid (1) matching and should only be
// written while no transaction is in flight.
// ---------------------------------------------------------------------------
module iupac_symbol_match (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ism_pkg::char_type req_first_char,
   input  ism_pkg::char_type req_second_char,
   output logic              rsp_strobe,
   output logic              rsp_is_match,
   input  logic              csr_write_en,
   input  logic              csr_wdata
);

   logic                  mode_ff;
   logic                  req_valid_ff;
   logic                  req_valid_in;
   ism_pkg::char_type     first_ff;
   ism_pkg::char_type     second_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_match_ff;
   logic                  rsp_match_in;
   ism_pkg::char_info_type first_info;
   ism_pkg::char_info_type second_info;
   logic                  match;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign rsp_match_in = req_valid_ff && match;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ism_pkg::AlphabetNucleotide;
      end else if (csr_write_en) begin
         mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_match_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
         rsp_match_ff <= rsp_match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         first_ff  <= req_first_char;
         second_ff <= req_second_char;
      end
   end

   ism_classify u_classify_first (
      .char_in (first_ff),
      .info    (first_info)
   );

   ism_classify u_classify_second (
      .char_in (second_ff),
      .info    (second_info)
   );

   ism_compare u_compare (
      .first_info    (first_info),
      .second_info   (second_info),
      .alphabet_mode (mode_ff),
      .is_match      (match)
   );

   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_is_match = rsp_match_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !reset) |=> ##1 rsp_strobe)
      else $error("transaction result not delivered after two cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without an accepted transaction");

   a_match_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> !rsp_is_match)
      else $error("match flag high outside a result cycle");

   a_gap_pair: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && first_info.gap && second_info.gap) |=> rsp_is_match)
      else $error("gap pair not reported as a match");
`endif

endmodule
